>>> src/pdc_pkg.sv
package pdc_pkg;

    // Field widths of the beats.
    localparam int ACT_W    = 2;
    localparam int CUR_W    = 10;
    localparam int POS_W    = 32;
    localparam int DRV_W    = 2;
    localparam int DUTY_W   = 8;
    localparam int MODE_W   = 2;
    localparam int PHASE_W  = 3;
    localparam int BAND_W   = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [ACT_W-1:0]  t_action;
    typedef logic [DRV_W-1:0]  t_drive;
    typedef logic [MODE_W-1:0] t_mode;

    localparam t_action ACT_ENCODER = 2'd0;
    localparam t_action ACT_TICK    = 2'd1;
    localparam t_action ACT_TARGET  = 2'd2;

    localparam t_drive DRV_STOP  = 2'd0;
    localparam t_drive DRV_BRAKE = 2'd1;
    localparam t_drive DRV_RIGHT = 2'd2;
    localparam t_drive DRV_LEFT  = 2'd3;

    localparam t_mode MODE_UNCAL  = 2'd0;
    localparam t_mode MODE_NORMAL = 2'd1;
    localparam t_mode MODE_ERROR  = 2'd2;

    localparam logic [DUTY_W-1:0] BRAKE_DUTY = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_OVERLOAD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_PWM = 3'd5;

    localparam logic [CUR_W-1:0]  RST_OVERLOAD = 10'd30;
    localparam logic [CUR_W-1:0]  RST_CALIB    = 10'd18;
    localparam logic [CUR_W-1:0]  RST_SETTLE   = 10'd15;
    localparam logic [BAND_W-1:0] RST_FAR      = 16'd20;
    localparam logic [BAND_W-1:0] RST_NEAR     = 16'd10;
    localparam logic [DUTY_W-1:0] RST_FULL_PWM = 8'd255;
    localparam logic [POS_W-1:0]  RST_WANTED   = 32'd100;

endpackage

>>> src/pdc_in_if.sv
interface pdc_in_if;
    import pdc_pkg::*;

    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic               pins_equal;
    logic [CUR_W-1:0]   current_sample;
    logic signed [POS_W-1:0] target_value;

    modport source(output valid, action, pins_equal, current_sample, target_value,
                   input ready);
    modport sink(input valid, action, pins_equal, current_sample, target_value,
                 output ready);
endinterface

>>> src/pdc_out_if.sv
interface pdc_out_if;
    import pdc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [DRV_W-1:0]        drive;
    logic [DUTY_W-1:0]       pwm_duty;
    logic [MODE_W-1:0]       op_mode;
    logic [CUR_W-1:0]        avg_current;
    logic signed [POS_W-1:0] position;
    logic signed [POS_W-1:0] target;

    modport source(output valid, drive, pwm_duty, op_mode, avg_current, position, target,
                   input ready);
    modport sink(input valid, drive, pwm_duty, op_mode, avg_current, position, target,
                 output ready);
endinterface

>>> src/position_drive_controller_unit.sv
// Channel   | Role   | Payload
// ----------+--------+---------------------------------------------------------
// i_in      | sink   | action, pins_equal, current_sample, target_value
// o_out     | source | drive, pwm_duty, op_mode, avg_current, position, target
// i_cfg_*   | write  | register index and data, no read-back
//
// One beat is accepted per clock when the output side keeps up. Every beat shows
// up as one result beat: it is first registered in the sample stage, then the
// control stage runs on it and loads the output register once that register is
// free or being read. The sample memory's registered read sets that
// first stage. Reset is synchronous and active low; it clears the
// sample valid bits and all control state at once, so there is no clearing pass.
// A stalled output holds its beat while one more input beat waits in the sample
// stage; after that the input ready drops.
module position_drive_controller_unit #(
    parameter int SAMPLES  = 10,
    parameter int ADC_BITS = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pdc_in_if.sink                           i_in,
    pdc_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pdc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import pdc_pkg::*;

    // Stored sample width: the converter field is 10 bits, and only the low
    // ADC_BITS of it count (all of it when ADC_BITS is larger).
    localparam int SAMP_W  = (ADC_BITS < CUR_W) ? ADC_BITS : CUR_W;
    localparam int CNT_W   = $clog2(SAMPLES);
    localparam int TOT_W   = SAMP_W + CNT_W;
    localparam int IDX_W   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    // The average is total * ceil(2^DIV_SH / SAMPLES) >> DIV_SH, which is exact
    // for every total below 2^TOT_W with this shift.
    localparam int DIV_SH  = TOT_W + CNT_W;
    localparam logic [DIV_SH:0] DIV_MUL =
        (DIV_SH + 1)'(((1 << DIV_SH) + SAMPLES - 1) / SAMPLES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES - 1);

    // Calibration phases.
    localparam logic [PHASE_W-1:0] PH_START  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LEFT   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SETTLE = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RIGHT  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CENTER = 3'd4;

    // ------------------------------------------------------------------
    // Configuration registers. They are to be written only while the block idles; the block does not enforce this.
    // ------------------------------------------------------------------
    logic [CUR_W-1:0]  r_overload;
    logic [CUR_W-1:0]  r_calib;
    logic [CUR_W-1:0]  r_settle;
    logic [BAND_W-1:0] r_far;
    logic [BAND_W-1:0] r_near;
    logic [DUTY_W-1:0] r_full_pwm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overload <= RST_OVERLOAD;
            r_calib    <= RST_CALIB;
            r_settle   <= RST_SETTLE;
            r_far      <= RST_FAR;
            r_near     <= RST_NEAR;
            r_full_pwm <= RST_FULL_PWM;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OVERLOAD: r_overload <= i_cfg_data[CUR_W-1:0];
                REG_CALIB:    r_calib    <= i_cfg_data[CUR_W-1:0];
                REG_SETTLE:   r_settle   <= i_cfg_data[CUR_W-1:0];
                REG_FAR:      r_far      <= i_cfg_data[BAND_W-1:0];
                REG_NEAR:     r_near     <= i_cfg_data[BAND_W-1:0];
                REG_FULL_PWM: r_full_pwm <= i_cfg_data[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake between the sample stage and the output register.
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_o_valid;
    logic s2_adv;
    logic in_acc;
    logic tick_acc;

    assign s2_adv     = r_s1_valid && (!r_o_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s2_adv;
    assign in_acc     = i_in.valid && i_in.ready;
    assign tick_acc   = in_acc && (i_in.action == ACT_TICK);

    // ------------------------------------------------------------------
    // Sample stage: ring memory with a registered read. The read address is
    // always the next write slot, so the oldest sample is waiting in r_rd when
    // the next tick arrives. A write to the slot being read is forwarded.
    // ------------------------------------------------------------------
    logic [SAMP_W-1:0]  r_ring [SAMPLES];
    logic [SAMPLES-1:0] r_ring_vld;
    logic [SAMP_W-1:0]  r_rd;
    logic [SAMP_W-1:0]  r_fwd_data;
    logic               r_fwd;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   n_idx;
    logic [TOT_W-1:0]   r_total;
    logic [TOT_W-1:0]   n_total;
    logic [SAMP_W-1:0]  r_avg;
    logic [SAMP_W-1:0]  n_avg;
    logic [SAMP_W-1:0]  samp;
    logic [SAMP_W-1:0]  old_samp;
    logic [TOT_W+DIV_SH:0] prod;

    assign samp     = i_in.current_sample[SAMP_W-1:0];
    // Slots never written since reset read as zero.
    assign old_samp = r_ring_vld[r_idx] ? (r_fwd ? r_fwd_data : r_rd) : '0;
    assign n_idx    = tick_acc ? ((r_idx == LAST_IDX) ? '0 : r_idx + 1'b1) : r_idx;
    assign n_total  = r_total - TOT_W'(old_samp) + TOT_W'(samp);
    assign prod     = n_total * DIV_MUL;
    assign n_avg    = prod[DIV_SH +: SAMP_W];

    always_ff @(posedge i_clk) begin
        if (tick_acc) begin
            r_ring[r_idx] <= samp;
        end
        r_rd       <= r_ring[n_idx];
        r_fwd_data <= samp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_total    <= '0;
            r_avg      <= '0;
            r_ring_vld <= '0;
            r_fwd      <= 1'b0;
        end else begin
            r_fwd <= tick_acc && (n_idx == r_idx);
            r_idx <= n_idx;
            if (tick_acc) begin
                r_ring_vld[r_idx] <= 1'b1;
                r_total           <= n_total;
                r_avg             <= n_avg;
            end
        end
    end

    // The item held in the sample stage. r_avg already includes it: a newer
    // beat is taken in only on the edge where this one moves on.
    logic [ACT_W-1:0]        r_s1_act;
    logic                    r_s1_pins;
    logic signed [POS_W-1:0] r_s1_target;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s2_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_act    <= i_in.action;
            r_s1_pins   <= i_in.pins_equal;
            r_s1_target <= i_in.target_value;
        end
    end

    // ------------------------------------------------------------------
    // Control stage: position count, target, mode, calibration sequence and
    // the bridge drive. Drive, duty, position and target registers feed the output.
    // ------------------------------------------------------------------
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [POS_W-1:0]   r_wanted, n_wanted;
    logic [POS_W-1:0]   r_right, n_right;
    logic [MODE_W-1:0]  r_mode, n_mode;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [DRV_W-1:0]   r_drv, n_drv;
    logic [DUTY_W-1:0]  r_duty, n_duty;
    logic [MODE_W-1:0]  r_o_mode, n_shown;
    logic [CUR_W-1:0]   r_o_avg;

    logic [CUR_W-1:0]   avg;
    logic               overload;
    logic               pwm_zero;
    logic [PHASE_W-1:0] phase;
    logic signed [POS_W+1:0] pos_err;
    logic signed [POS_W+1:0] far_s;
    logic signed [POS_W+1:0] near_s;
    logic [POS_W-1:0]   half_right;

    assign avg      = CUR_W'(r_avg);
    assign overload = avg > r_overload;
    assign pwm_zero = r_full_pwm == '0;
    assign phase    = (r_phase > PH_CENTER) ? PH_START : r_phase;
    assign pos_err  = $signed({{2{r_wanted[POS_W-1]}}, r_wanted})
                    - $signed({{2{r_pos[POS_W-1]}}, r_pos});
    assign far_s    = $signed({{(POS_W+2-BAND_W){1'b0}}, r_far});
    assign near_s   = $signed({{(POS_W+2-BAND_W){1'b0}}, r_near});
    // Halving rounds toward zero: add one to a negative value before the shift.
    assign half_right = POS_W'($signed(r_right + {{(POS_W-1){1'b0}}, r_right[POS_W-1]})
                               >>> 1);

    always_comb begin
        n_pos    = r_pos;
        n_wanted = r_wanted;
        n_right  = r_right;
        n_mode   = r_mode;
        n_phase  = r_phase;
        n_drv    = r_drv;
        n_duty   = r_duty;
        n_shown  = r_mode;
        case (r_s1_act)
            ACT_ENCODER: begin
                n_pos = r_s1_pins ? r_pos + 1'b1 : r_pos - 1'b1;
            end
            ACT_TICK: begin
                if (r_mode == MODE_ERROR) begin
                    n_drv   = DRV_STOP;
                    n_duty  = '0;
                    n_mode  = MODE_NORMAL;
                    n_shown = MODE_NORMAL;
                end else if (r_mode == MODE_UNCAL) begin
                    case (phase)
                        PH_START, PH_LEFT: begin
                            if (phase == PH_START) begin
                                n_pos = '0;
                            end
                            n_phase = PH_LEFT;
                            if (overload || pwm_zero) begin
                                n_drv  = DRV_STOP;
                                n_duty = '0;
                            end else begin
                                n_drv  = DRV_LEFT;
                                n_duty = r_full_pwm;
                            end
                            // Overload during calibration shows only in this result.
                            if (overload) begin
                                n_shown = MODE_ERROR;
                            end
                            if (avg >= r_calib) begin
                                n_pos   = '0;
                                n_drv   = DRV_STOP;
                                n_duty  = '0;
                                n_phase = PH_SETTLE;
                            end
                        end
                        PH_SETTLE: begin
                            n_drv  = DRV_STOP;
                            n_duty = '0;
                            if (avg <= r_settle) begin
                                n_phase = PH_RIGHT;
                            end
                        end
                        PH_RIGHT: begin
                            if (overload || pwm_zero) begin
                                n_drv  = DRV_STOP;
                                n_duty = '0;
                            end else begin
                                n_drv  = DRV_RIGHT;
                                n_duty = r_full_pwm;
                            end
                            if (overload) begin
                                n_shown = MODE_ERROR;
                            end
                            if (avg >= r_calib) begin
                                n_right = r_pos;
                                n_drv   = DRV_STOP;
                                n_duty  = '0;
                                n_phase = PH_CENTER;
                            end
                        end
                        default: begin
                            n_drv  = DRV_STOP;
                            n_duty = '0;
                            if (avg <= r_settle) begin
                                n_wanted = half_right;
                                n_mode   = MODE_NORMAL;
                                n_shown  = MODE_NORMAL;
                                n_phase  = PH_START;
                            end
                        end
                    endcase
                end else begin
                    if ((pos_err > far_s) || (pos_err < -far_s)) begin
                        if (overload || pwm_zero) begin
                            n_drv  = DRV_STOP;
                            n_duty = '0;
                        end else begin
                            n_drv  = (pos_err > far_s) ? DRV_RIGHT : DRV_LEFT;
                            n_duty = r_full_pwm;
                        end
                        if (overload) begin
                            n_mode  = MODE_ERROR;
                            n_shown = MODE_ERROR;
                        end
                    end else if ((pos_err > near_s) || (pos_err < -near_s)) begin
                        n_drv  = DRV_BRAKE;
                        n_duty = BRAKE_DUTY;
                    end else begin
                        n_drv  = DRV_STOP;
                        n_duty = '0;
                    end
                end
            end
            ACT_TARGET: begin
                n_wanted = r_s1_target;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_wanted  <= RST_WANTED;
            r_right   <= '0;
            r_mode    <= MODE_UNCAL;
            r_phase   <= PH_START;
            r_drv     <= DRV_STOP;
            r_duty    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (s2_adv) begin
                r_pos     <= n_pos;
                r_wanted  <= n_wanted;
                r_right   <= n_right;
                r_mode    <= n_mode;
                r_phase   <= n_phase;
                r_drv     <= n_drv;
                r_duty    <= n_duty;
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // The average moves on when the next beat enters, so the output keeps a copy.
    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_o_mode <= n_shown;
            r_o_avg  <= avg;
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.drive       = r_drv;
    assign o_out.pwm_duty    = r_duty;
    assign o_out.op_mode     = r_o_mode;
    assign o_out.avg_current = r_o_avg;
    assign o_out.position    = r_pos;
    assign o_out.target      = r_wanted;

endmodule

>>> src/pdc_checker.sv
module pdc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [pdc_pkg::DRV_W-1:0]     i_drive,
    input logic [pdc_pkg::DUTY_W-1:0]    i_pwm_duty,
    input logic [pdc_pkg::MODE_W-1:0]    i_op_mode,
    input logic [pdc_pkg::CUR_W-1:0]     i_avg_current,
    input logic [pdc_pkg::POS_W-1:0]     i_position,
    input logic [pdc_pkg::POS_W-1:0]     i_target
);
    import pdc_pkg::*;

    // Beats taken in but not yet delivered: the sample stage and the output
    // register hold at most two.
    logic [1:0] r_outstanding;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else if (in_acc && !out_acc) begin
            r_outstanding <= r_outstanding + 1'b1;
        end else if (out_acc && !in_acc) begin
            r_outstanding <= r_outstanding - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_drive)
            && $stable(i_pwm_duty) && $stable(i_op_mode) && $stable(i_avg_current)
            && $stable(i_position) && $stable(i_target))
        else $error("result beat changed while stalled");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_outstanding != 2'd3) and (i_out_valid |-> r_outstanding != 2'd0))
        else $error("result count does not match accepted beats");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while the output register is empty");

    a_brake_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_drive == DRV_BRAKE) |-> (i_pwm_duty == BRAKE_DUTY)
            && (i_op_mode == MODE_NORMAL))
        else $error("brake outside normal mode or with wrong duty");

endmodule

bind position_drive_controller_unit pdc_checker u_pdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_drive       (o_out.drive),
    .i_pwm_duty    (o_out.pwm_duty),
    .i_op_mode     (o_out.op_mode),
    .i_avg_current (o_out.avg_current),
    .i_position    (o_out.position),
    .i_target      (o_out.target)
);

>>> tb/tb_position_drive_controller_unit.sv
`timescale 1ns / 1ps

module tb_position_drive_controller_unit;
    import pdc_pkg::*;

    localparam int SAMPLE_DEPTH = 10;
    localparam int LATENCY      = 2;
    // How long the result side refuses beats when the test asks for back-pressure.
    localparam int LONG_HOLD    = 64;
    localparam int SEGMENTS     = 20;
    localparam int SEG_BEATS    = 50;

    // The block ignores this action code, so it has no name in the package.
    localparam t_action ACT_UNUSED = 2'd3;

    // Calibration steps as the block walks through them after reset.
    typedef enum logic [PHASE_W-1:0] {
        CAL_START, CAL_LEFT, CAL_SETTLE_L, CAL_RIGHT, CAL_SETTLE_R
    } cal_phase_e;

    typedef enum int {LOAD_LIGHT, LOAD_HEAVY, LOAD_MIXED} load_profile_e;

    typedef struct packed {
        t_action                 action;
        logic                    pins_equal;
        logic [CUR_W-1:0]        sample;
        logic [POS_W-1:0]        target;
    } drive_cmd_t;

    typedef struct packed {
        t_drive                  drive;
        logic [DUTY_W-1:0]       duty;
        t_mode                   mode;
        logic [CUR_W-1:0]        avg;
        logic [POS_W-1:0]        pos;
        logic [POS_W-1:0]        tgt;
    } drive_result_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Everything the testbench drives starts at a known value before the first edge.
    logic                   cmd_valid  = 1'b0;
    drive_cmd_t             cmd_on_bus = '0;
    logic                   res_ready  = 1'b0;
    logic                   cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;

    pdc_in_if  cmd_if ();
    pdc_out_if res_if ();

    assign cmd_if.valid          = cmd_valid;
    assign cmd_if.action         = cmd_on_bus.action;
    assign cmd_if.pins_equal     = cmd_on_bus.pins_equal;
    assign cmd_if.current_sample = cmd_on_bus.sample;
    assign cmd_if.target_value   = cmd_on_bus.target;
    assign res_if.ready          = res_ready;

    position_drive_controller_unit #(
        .SAMPLES  (SAMPLE_DEPTH),
        .ADC_BITS (CUR_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (cmd_if),
        .o_out      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Commands waiting to be offered, and the outputs predicted for accepted beats.
    drive_cmd_t    pending_cmds[$];
    drive_result_t expected_drive_outputs[$];
    int            error_count   = 0;
    bit            idle_on       = 1'b0;
    int            hold_requests = 0;

    // ------------------------------------------------------------------
    // Predictor state. It starts at the reset values, since reset is applied
    // only once at the start of the run.
    // ------------------------------------------------------------------
    logic [CUR_W-1:0]   cfg_overload = RST_OVERLOAD;
    logic [CUR_W-1:0]   cfg_calib    = RST_CALIB;
    logic [CUR_W-1:0]   cfg_settle   = RST_SETTLE;
    logic [BAND_W-1:0]  cfg_far      = RST_FAR;
    logic [BAND_W-1:0]  cfg_near     = RST_NEAR;
    logic [DUTY_W-1:0]  cfg_full     = RST_FULL_PWM;

    logic [POS_W-1:0]   m_pos    = '0;
    logic [POS_W-1:0]   m_wanted = RST_WANTED;
    t_mode              m_mode   = MODE_UNCAL;
    cal_phase_e         m_phase  = CAL_START;
    logic [CUR_W-1:0]   m_ring [SAMPLE_DEPTH] = '{default: '0};
    int                 m_slot   = 0;
    logic [13:0]        m_total  = '0;
    logic [CUR_W-1:0]   m_avg    = '0;
    logic [POS_W-1:0]   m_right  = '0;
    t_drive             m_drive  = DRV_STOP;
    logic [DUTY_W-1:0]  m_duty   = '0;

    function automatic void halt_motor();
        m_drive = DRV_STOP;
        m_duty  = '0;
    endfunction

    // The running total never goes negative: the sample taken out is part of it.
    function automatic void push_current(logic [CUR_W-1:0] s);
        m_total = m_total - m_ring[m_slot] + s;
        m_ring[m_slot] = s;
        m_slot = (m_slot == SAMPLE_DEPTH - 1) ? 0 : m_slot + 1;
        m_avg = CUR_W'(m_total / SAMPLE_DEPTH);
    endfunction

    // Returns 1 when the overload check stopped the motor instead.
    function automatic bit run_motor(t_drive dir);
        if (m_avg > cfg_overload) begin
            halt_motor();
            return 1'b1;
        end
        if (cfg_full == '0) begin
            halt_motor();
        end else begin
            m_drive = dir;
            m_duty  = cfg_full;
        end
        return 1'b0;
    endfunction

    // One calibration step per control tick. The return value flags an overload,
    // which shows as error mode in this result only.
    function automatic bit calibrate_tick();
        bit overload = 1'b0;
        case (m_phase)
            CAL_START, CAL_LEFT: begin
                if (m_phase == CAL_START) begin
                    m_pos   = '0;
                    m_phase = CAL_LEFT;
                end
                overload = run_motor(DRV_LEFT);
                if (m_avg >= cfg_calib) begin
                    m_pos = '0;
                    halt_motor();
                    m_phase = CAL_SETTLE_L;
                end
            end
            CAL_SETTLE_L: begin
                halt_motor();
                if (m_avg <= cfg_settle) m_phase = CAL_RIGHT;
            end
            CAL_RIGHT: begin
                overload = run_motor(DRV_RIGHT);
                if (m_avg >= cfg_calib) begin
                    m_right = m_pos;
                    halt_motor();
                    m_phase = CAL_SETTLE_R;
                end
            end
            default: begin
                halt_motor();
                if (m_avg <= cfg_settle) begin
                    // Signed division truncates toward zero, as the block must.
                    m_wanted = POS_W'($signed(m_right) / 2);
                    m_mode   = MODE_NORMAL;
                    m_phase  = CAL_START;
                end
            end
        endcase
        return overload;
    endfunction

    // Position error is taken at 64 bits so that wrapped extremes compare correctly.
    function automatic void track_target();
        longint pos_err;
        longint pos_mag;
        pos_err = longint'($signed(m_wanted)) - longint'($signed(m_pos));
        pos_mag = (pos_err < 0) ? -pos_err : pos_err;
        if (pos_err > longint'(cfg_far)) begin
            if (run_motor(DRV_RIGHT)) m_mode = MODE_ERROR;
        end else if (pos_err < -longint'(cfg_far)) begin
            if (run_motor(DRV_LEFT)) m_mode = MODE_ERROR;
        end else if (pos_mag > longint'(cfg_near)) begin
            m_drive = DRV_BRAKE;
            m_duty  = BRAKE_DUTY;
        end else begin
            halt_motor();
        end
    endfunction

    // Advances the predictor by one accepted beat and returns the outputs it shows.
    function automatic drive_result_t compute_drive_outputs(drive_cmd_t c);
        drive_result_t r;
        bit            flash_error = 1'b0;
        case (c.action)
            ACT_ENCODER: m_pos = c.pins_equal ? m_pos + 1'b1 : m_pos - 1'b1;
            ACT_TICK: begin
                push_current(c.sample);
                if (m_mode == MODE_ERROR) begin
                    halt_motor();
                    m_mode = MODE_NORMAL;
                end else if (m_mode == MODE_UNCAL) begin
                    flash_error = calibrate_tick();
                end else begin
                    track_target();
                end
            end
            ACT_TARGET: m_wanted = c.target;
            default: ;
        endcase
        r.drive = m_drive;
        r.duty  = m_duty;
        r.mode  = flash_error ? MODE_ERROR : m_mode;
        r.avg   = m_avg;
        r.pos   = m_pos;
        r.tgt   = m_wanted;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    function automatic void check_field(string field, logic [POS_W-1:0] want,
                                        logic [POS_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            error_count++;
        end
    endfunction

    function automatic void compare_result(drive_result_t got);
        drive_result_t want;
        if (expected_drive_outputs.size() == 0) begin
            $error("output beat arrived with no expectation pending");
            error_count++;
            return;
        end
        want = expected_drive_outputs.pop_front();
        check_field("drive", POS_W'(want.drive), POS_W'(got.drive));
        check_field("pwm_duty", POS_W'(want.duty), POS_W'(got.duty));
        check_field("op_mode", POS_W'(want.mode), POS_W'(got.mode));
        check_field("avg_current", POS_W'(want.avg), POS_W'(got.avg));
        check_field("position", want.pos, got.pos);
        check_field("target", want.tgt, got.tgt);
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver. A beat is accepted at an edge where valid and ready were both
    // high; the prediction is made right there from the command on the bus.
    // The next command, or a gap, is put up once the current one is gone.
    // ------------------------------------------------------------------
    int send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_valid <= 1'b0;
        end else begin
            if (cmd_valid && cmd_if.ready)
                expected_drive_outputs.push_back(compute_drive_outputs(cmd_on_bus));
            if (!cmd_valid || cmd_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    cmd_valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    cmd_on_bus <= pending_cmds.pop_front();
                    cmd_valid  <= 1'b1;
                    send_gap = idle_on ? idle_gap() : 0;
                end else begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Checks every accepted result beat and drives ready: random
    // stalls while idling is on, and a long hold whenever the stimulus asks.
    // ------------------------------------------------------------------
    int stall_left  = 0;
    int hold_served = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (res_if.valid && res_ready)
                compare_result('{drive: res_if.drive, duty: res_if.pwm_duty,
                                 mode: res_if.op_mode, avg: res_if.avg_current,
                                 pos: res_if.position, tgt: res_if.target});
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                stall_left  = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0) stall_left = idle_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. The stimulus process touches the shared queues only on
    // falling edges, so it never races the driver and monitor over them.
    // ------------------------------------------------------------------
    function automatic void queue_cmd(t_action a, logic eq, logic [CUR_W-1:0] s,
                                      logic [POS_W-1:0] t);
        pending_cmds.push_back('{action: a, pins_equal: eq, sample: s, target: t});
    endfunction

    // Returns once nothing is queued, on the bus or awaiting its result.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || cmd_valid || expected_drive_outputs.size() != 0);
    endtask

    // Only the register's own bits count; the bits above it carry random junk.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom());
        case (idx)
            REG_FAR, REG_NEAR: junk = '0;
            REG_FULL_PWM:      junk[DUTY_W-1:0] = '0;
            default:           junk[CUR_W-1:0] = '0;
        endcase
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value | junk;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_OVERLOAD: cfg_overload = value[CUR_W-1:0];
            REG_CALIB:    cfg_calib    = value[CUR_W-1:0];
            REG_SETTLE:   cfg_settle   = value[CUR_W-1:0];
            REG_FAR:      cfg_far      = value[BAND_W-1:0];
            REG_NEAR:     cfg_near     = value[BAND_W-1:0];
            REG_FULL_PWM: cfg_full     = value[DUTY_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Segment 1 takes every register to its low end and segment 2 to its high end;
    // elsewhere the ends still turn up now and then.
    function automatic int pick_setting(int seg, int hi, int usual_hi);
        int roll;
        if (seg == 1) return 0;
        if (seg == 2) return hi;
        roll = $urandom_range(0, 99);
        if (roll < 12) return 0;
        if (roll < 24) return hi;
        if (roll < 32) return $urandom_range(0, hi);
        return $urandom_range(0, usual_hi);
    endfunction

    function automatic logic [CUR_W-1:0] pick_current(load_profile_e load);
        case (load)
            LOAD_LIGHT: return CUR_W'($urandom_range(0, cfg_overload));
            LOAD_HEAVY: return CUR_W'($urandom_range(cfg_overload, 1023));
            default:    return CUR_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // Feeds calibration-shaped traffic until the block reaches normal mode or sixty rounds have run:
    // low current while it settles, encoder motion and rising current while it runs.
    task automatic finish_calibration();
        int rounds = 0;
        while (m_mode == MODE_UNCAL && rounds < 60) begin
            rounds++;
            if (m_phase == CAL_SETTLE_L || m_phase == CAL_SETTLE_R) begin
                repeat (4) queue_cmd(ACT_TICK, 1'b0,
                                     CUR_W'($urandom_range(0, cfg_settle)), '0);
                queue_cmd(ACT_ENCODER, 1'($urandom_range(0, 1)), '0, '0);
            end else begin
                // The right run counts mostly upward so that the middle is not zero.
                repeat ($urandom_range(3, 8))
                    queue_cmd(ACT_ENCODER,
                              (m_phase == CAL_RIGHT) ? ($urandom_range(0, 4) != 0)
                                                     : 1'($urandom_range(0, 1)),
                              CUR_W'($urandom()), POS_W'($urandom()));
                if (rounds < 6 && cfg_calib > 0)
                    queue_cmd(ACT_TICK, 1'b0, CUR_W'($urandom_range(0, cfg_calib - 1)), '0);
                repeat (3) queue_cmd(ACT_TICK, 1'b0,
                                     CUR_W'($urandom_range(cfg_calib, 1023)), '0);
            end
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int            seg;
        int            beats;
        int            span;
        int            offset;
        int            roll;
        bit            head_up;
        load_profile_e load;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed opening at reset settings: target extremes, both encoder
        // directions with a wrap below zero, an ignored action, and the first
        // calibration steps with the current at both ends of its range.
        queue_cmd(ACT_TARGET, 1'b0, '0, 32'h7FFF_FFFF);
        queue_cmd(ACT_TARGET, 1'b1, '1, 32'h8000_0000);
        queue_cmd(ACT_ENCODER, 1'b0, '0, '0);
        queue_cmd(ACT_ENCODER, 1'b1, '1, '1);
        queue_cmd(ACT_ENCODER, 1'b0, '1, '0);
        queue_cmd(ACT_UNUSED, 1'b1, '1, '1);
        queue_cmd(ACT_TARGET, 1'b0, '0, '1);
        // The first tick zeroes the position and starts the left run.
        queue_cmd(ACT_TICK, 1'b0, '0, '0);
        // A full-scale sample overloads the left run and also marks the end stop.
        queue_cmd(ACT_TICK, 1'b0, '1, '0);
        // The big sample has to leave the average before settling ends.
        repeat (SAMPLE_DEPTH) queue_cmd(ACT_TICK, 1'b0, '0, '0);
        repeat (3) queue_cmd(ACT_ENCODER, 1'b1, '0, '0);
        queue_cmd(ACT_TICK, 1'b0, '0, '0);
        wait_idle();

        // With a zero run duty the right run turns into a stop.
        write_reg(REG_FULL_PWM, '0);
        idle_on = 1'b1;
        queue_cmd(ACT_TICK, 1'b0, '0, '0);
        repeat (2) queue_cmd(ACT_ENCODER, 1'b1, '0, '0);
        queue_cmd(ACT_TICK, 1'b0, '0, '0);
        wait_idle();

        write_reg(REG_FULL_PWM, DUTY_W'($urandom_range(1, 254)));
        write_reg(REG_CALIB, CUR_W'($urandom_range(40, 300)));
        write_reg(REG_SETTLE, CUR_W'($urandom_range(0, 30)));
        write_reg(REG_OVERLOAD, CUR_W'($urandom_range(60, 1023)));
        finish_calibration();

        // Normal mode. Each segment may reconfigure, then mixes targets near the
        // current position, encoder motion with a preferred direction and ticks
        // under one load profile. The sender always drains between segments.
        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 0 || seg == 1 || seg == 2 || $urandom_range(0, 2) == 0) begin
                write_reg(REG_FAR, BAND_W'(pick_setting(seg, 65535, 60)));
                write_reg(REG_NEAR, BAND_W'(pick_setting(seg, 65535, 40)));
                write_reg(REG_OVERLOAD, CUR_W'(pick_setting(seg, 1023, 400)));
                write_reg(REG_FULL_PWM, DUTY_W'(pick_setting(seg, 255, 255)));
                write_reg(REG_CALIB, CUR_W'(pick_setting(seg, 1023, 1023)));
                write_reg(REG_SETTLE, CUR_W'(pick_setting(seg, 1023, 1023)));
            end

            // The first segment runs without idling; later ones mostly idle.
            idle_on = (seg != 0) && ($urandom_range(0, 3) != 0);
            // Twice the result side holds off while commands keep coming, so the
            // block fills and has to drop its input ready.
            if (seg == 3 || seg == 11) hold_requests++;

            load    = load_profile_e'($urandom_range(0, 2));
            head_up = 1'($urandom_range(0, 1));
            span    = (cfg_far > 2000) ? 70000 : int'(cfg_far) + int'(cfg_near) + 30;
            beats   = 0;
            while (beats < SEG_BEATS) begin
                roll = $urandom_range(0, 99);
                if (roll < 40) begin
                    queue_cmd(ACT_ENCODER,
                              ($urandom_range(0, 3) != 0) ? head_up : 1'($urandom_range(0, 1)),
                              CUR_W'($urandom()), POS_W'($urandom()));
                    beats++;
                end else if (roll < 80) begin
                    queue_cmd(ACT_TICK, 1'($urandom_range(0, 1)), pick_current(load),
                              POS_W'($urandom()));
                    beats++;
                end else if (roll < 96) begin
                    offset = $urandom_range(0, 2 * span) - span;
                    queue_cmd(ACT_TARGET, 1'($urandom_range(0, 1)), CUR_W'($urandom()),
                              ($urandom_range(0, 4) != 0) ? m_pos + POS_W'(offset)
                                                          : POS_W'($urandom()));
                    beats++;
                end else begin
                    // Ignored by the block, so it does not count as a beat of work.
                    queue_cmd(ACT_UNUSED, 1'($urandom_range(0, 1)), CUR_W'($urandom()),
                              POS_W'($urandom()));
                end
            end
            wait_idle();
        end

        // Give the pipeline time to show any stray beat.
        repeat (2 * LATENCY + 4) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Far beyond the slowest correct run: every beat waiting out the longest
    // sender gap and receiver stall, plus the long holds and the drains.
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
